// ===== rtl/split_screen_viewport_tiler_macros.svh =====
`ifndef SPLIT_SCREEN_VIEWPORT_TILER_MACROS_SVH
`define SPLIT_SCREEN_VIEWPORT_TILER_MACROS_SVH

// Same-cycle implication, checked on clock, quiet while reset is high
`define SSVT_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("viewport tiler check failed");

// Next-cycle implication, checked on clock, quiet while reset is high
`define SSVT_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("viewport tiler check failed");

`endif

// ===== rtl/ssvt_pkg.sv =====
`timescale 1ns / 1ps

package ssvt_pkg;

   localparam int DIM_W      = 14;
   localparam int CNT_W      = 7;
   localparam int IDX_W      = 6;
   localparam int DVS_W      = 4;
   localparam int STEP_W     = $clog2(DIM_W + 1);
   localparam int MAX_VIEWS  = 64;
   localparam int RESULT_CAP = 64;

   localparam logic [CNT_W-1:0] VIEW_CAP =
      CNT_W'((MAX_VIEWS < RESULT_CAP) ? MAX_VIEWS : RESULT_CAP);

   localparam logic CSR_FRAME_WIDTH  = 1'b0;
   localparam logic CSR_FRAME_HEIGHT = 1'b1;

   typedef struct packed {
      logic             go;
      logic [DIM_W-1:0] dividend;
      logic [DVS_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [DIM_W-1:0] quotient;
      logic [DVS_W-1:0] remainder;
   } div_rsp_type;

endpackage

// ===== rtl/ssvt_divider.sv =====
`timescale 1ns / 1ps

module ssvt_divider import ssvt_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  div_req_type req,
   output div_rsp_type rsp
);

   logic [DIM_W-1:0]  quo_ff, quo_in;
   logic [DVS_W-1:0]  rem_ff, rem_in;
   logic [DVS_W-1:0]  dvs_ff, dvs_in;
   logic [STEP_W-1:0] cnt_ff, cnt_in;
   logic              active_ff, active_in;
   logic              done_ff, done_in;
   logic [DVS_W:0]    trial;
   logic              fits;

   // one quotient bit per cycle, restoring
   assign trial = {rem_ff, quo_ff[DIM_W-1]};
   assign fits  = (trial >= {1'b0, dvs_ff});

   always_comb begin
      quo_in    = quo_ff;
      rem_in    = rem_ff;
      dvs_in    = dvs_ff;
      cnt_in    = cnt_ff;
      active_in = active_ff;
      done_in   = 1'b0;
      if (req.go) begin
         quo_in    = req.dividend;
         rem_in    = '0;
         dvs_in    = req.divisor;
         cnt_in    = STEP_W'(DIM_W);
         active_in = 1'b1;
      end else if (active_ff) begin
         quo_in = {quo_ff[DIM_W-2:0], fits};
         rem_in = fits ? DVS_W'(trial - {1'b0, dvs_ff}) : DVS_W'(trial);
         cnt_in = cnt_ff - STEP_W'(1);
         if (cnt_ff == STEP_W'(1)) begin
            active_in = 1'b0;
            done_in   = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         done_ff   <= 1'b0;
      end else begin
         active_ff <= active_in;
         done_ff   <= done_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      cnt_ff <= cnt_in;
   end

   assign rsp.done      = done_ff;
   assign rsp.quotient  = quo_ff;
   assign rsp.remainder = rem_ff;

endmodule

// ===== rtl/split_screen_viewport_tiler.sv =====
`timescale 1ns / 1ps
// A request places N views in R = ceil(sqrt(N)) rows. busy is high from accept until the
// last view is registered into the outputs, so a new request is taken only once the
// previous one has been worked through; start is ignored while busy.
// Each division (N/R, height/R, width/cols per row) holds its state until done on the
// shared divider; after each row's width divide its rectangles leave one per cycle.
// Results are strobed on rsp_valid for one cycle each; the receiver cannot stall.
// Reset (synchronous, active high) clears the frame size to zero and returns to idle.

module split_screen_viewport_tiler import ssvt_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [CNT_W-1:0] req_view_count,
   output logic             busy,
   input  logic             csr_wr_en,
   input  logic             csr_index,
   input  logic [DIM_W-1:0] csr_wdata,
   output logic             rsp_valid,
   output logic [IDX_W-1:0] rsp_view_index,
   output logic [DIM_W-1:0] rsp_x_origin,
   output logic [DIM_W-1:0] rsp_y_origin,
   output logic [DIM_W-1:0] rsp_view_width,
   output logic [DIM_W-1:0] rsp_view_height,
   output logic             rsp_last_view
);

   `include "split_screen_viewport_tiler_macros.svh"

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_ROOT  = 3'd1;
   localparam logic [2:0] S_DIV_N = 3'd2;
   localparam logic [2:0] S_DIV_H = 3'd3;
   localparam logic [2:0] S_DIV_W = 3'd4;
   localparam logic [2:0] S_EMIT  = 3'd5;

   logic [2:0]       state_ff, state_in;
   logic [DIM_W-1:0] frame_width_ff, frame_height_ff;
   logic [CNT_W-1:0] n_ff, n_in;
   logic [DVS_W-1:0] rows_ff, rows_in;
   logic [DVS_W-1:0] minc_ff, minc_in;
   logic [DVS_W-1:0] maxc_ff, maxc_in;
   logic [DVS_W-1:0] min_rows_ff, min_rows_in;
   logic [DVS_W-1:0] row_ff, row_in;
   logic [DVS_W-1:0] col_ff, col_in;
   logic [DVS_W-1:0] cols_ff, cols_in;
   logic [IDX_W-1:0] k_ff, k_in;
   logic [DIM_W-1:0] hq_ff, hq_in;
   logic [DIM_W-1:0] wq_ff, wq_in;
   logic [DIM_W-1:0] alloc_w_ff, alloc_w_in;
   logic [DIM_W-1:0] alloc_h_ff, alloc_h_in;

   logic             out_valid_ff, out_valid_in;
   logic [IDX_W-1:0] out_index_ff;
   logic [DIM_W-1:0] out_x_ff, out_y_ff, out_w_ff, out_h_ff;
   logic             out_last_ff, out_last_in;

   div_req_type      div_req;
   div_rsp_type      div_rsp;

   logic [CNT_W-1:0] n_sat;
   logic [7:0]       rows_sq;
   logic [DVS_W-1:0] maxc_new;
   logic [7:0]       span;
   logic             last_col, last_row;
   logic [DIM_W-1:0] cur_w, cur_h;
   logic [DVS_W-1:0] next_row;
   logic [DVS_W-1:0] next_cols;

   ssvt_divider u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   assign n_sat    = (req_view_count > VIEW_CAP) ? VIEW_CAP : req_view_count;
   assign rows_sq  = {4'b0, rows_ff} * {4'b0, rows_ff};
   assign maxc_new = div_rsp.quotient[DVS_W-1:0] + DVS_W'(div_rsp.remainder != '0);
   assign span     = {4'b0, rows_ff} * {4'b0, maxc_new};
   assign last_col = (col_ff + DVS_W'(1)) == cols_ff;
   assign last_row = (row_ff + DVS_W'(1)) == rows_ff;
   // last column and last row soak up the leftover
   assign cur_w    = last_col ? (frame_width_ff - alloc_w_ff) : wq_ff;
   assign cur_h    = last_row ? (frame_height_ff - alloc_h_ff) : hq_ff;
   assign next_row = (state_ff == S_EMIT) ? (row_ff + DVS_W'(1)) : '0;
   assign next_cols = (next_row < min_rows_ff) ? minc_ff : maxc_ff;

   always_comb begin
      state_in     = state_ff;
      n_in         = n_ff;
      rows_in      = rows_ff;
      minc_in      = minc_ff;
      maxc_in      = maxc_ff;
      min_rows_in  = min_rows_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      cols_in      = cols_ff;
      k_in         = k_ff;
      hq_in        = hq_ff;
      wq_in        = wq_ff;
      alloc_w_in   = alloc_w_ff;
      alloc_h_in   = alloc_h_ff;
      out_valid_in = 1'b0;
      out_last_in  = 1'b0;
      div_req      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (start && n_sat != '0 && frame_width_ff != '0 && frame_height_ff != '0) begin
               n_in     = n_sat;
               rows_in  = DVS_W'(1);
               state_in = S_ROOT;
            end
         end
         S_ROOT: begin
            // advance until rows squared covers the count
            if (rows_sq < {1'b0, n_ff}) begin
               rows_in = rows_ff + DVS_W'(1);
            end else begin
               div_req.go       = 1'b1;
               div_req.dividend = DIM_W'(n_ff);
               div_req.divisor  = rows_ff;
               state_in         = S_DIV_N;
            end
         end
         S_DIV_N: begin
            if (div_rsp.done) begin
               minc_in          = div_rsp.quotient[DVS_W-1:0];
               maxc_in          = maxc_new;
               min_rows_in      = (div_rsp.remainder != '0) ?
                                  DVS_W'(span - {1'b0, n_ff}) : '0;
               div_req.go       = 1'b1;
               div_req.dividend = frame_height_ff;
               div_req.divisor  = rows_ff;
               state_in         = S_DIV_H;
            end
         end
         S_DIV_H: begin
            if (div_rsp.done) begin
               hq_in            = div_rsp.quotient;
               row_in           = '0;
               k_in             = '0;
               alloc_h_in       = '0;
               cols_in          = next_cols;
               div_req.go       = 1'b1;
               div_req.dividend = frame_width_ff;
               div_req.divisor  = next_cols;
               state_in         = S_DIV_W;
            end
         end
         S_DIV_W: begin
            if (div_rsp.done) begin
               wq_in      = div_rsp.quotient;
               col_in     = '0;
               alloc_w_in = '0;
               state_in   = S_EMIT;
            end
         end
         S_EMIT: begin
            out_valid_in = 1'b1;
            out_last_in  = ({1'b0, k_ff} + CNT_W'(1)) == n_ff;
            alloc_w_in   = alloc_w_ff + cur_w;
            col_in       = col_ff + DVS_W'(1);
            k_in         = k_ff + IDX_W'(1);
            if (out_last_in) begin
               state_in = S_IDLE;
            end else if (last_col) begin
               alloc_h_in       = alloc_h_ff + hq_ff;
               row_in           = next_row;
               cols_in          = next_cols;
               div_req.go       = 1'b1;
               div_req.dividend = frame_width_ff;
               div_req.divisor  = next_cols;
               state_in         = S_DIV_W;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         out_valid_ff    <= 1'b0;
         frame_width_ff  <= '0;
         frame_height_ff <= '0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
         if (csr_wr_en) begin
            unique case (csr_index)
               CSR_FRAME_WIDTH:  frame_width_ff  <= csr_wdata;
               CSR_FRAME_HEIGHT: frame_height_ff <= csr_wdata;
            endcase
         end
      end
      n_ff        <= n_in;
      rows_ff     <= rows_in;
      minc_ff     <= minc_in;
      maxc_ff     <= maxc_in;
      min_rows_ff <= min_rows_in;
      row_ff      <= row_in;
      col_ff      <= col_in;
      cols_ff     <= cols_in;
      k_ff        <= k_in;
      hq_ff       <= hq_in;
      wq_ff       <= wq_in;
      alloc_w_ff  <= alloc_w_in;
      alloc_h_ff  <= alloc_h_in;
      if (out_valid_in) begin
         out_index_ff <= k_ff;
         out_x_ff     <= alloc_w_ff;
         out_y_ff     <= frame_height_ff - (alloc_h_ff + cur_h);
         out_w_ff     <= cur_w;
         out_h_ff     <= cur_h;
         out_last_ff  <= out_last_in;
      end
   end

   assign busy            = (state_ff != S_IDLE);
   assign rsp_valid       = out_valid_ff;
   assign rsp_view_index  = out_index_ff;
   assign rsp_x_origin    = out_x_ff;
   assign rsp_y_origin    = out_y_ff;
   assign rsp_view_width  = out_w_ff;
   assign rsp_view_height = out_h_ff;
   assign rsp_last_view   = out_last_ff;

   logic [DIM_W:0] x_end, y_end;
   assign x_end = {1'b0, rsp_x_origin} + {1'b0, rsp_view_width};
   assign y_end = {1'b0, rsp_y_origin} + {1'b0, rsp_view_height};

   `SSVT_ASSERT_NEXT(a_gap_after_last, rsp_valid && rsp_last_view, !rsp_valid)
   `SSVT_ASSERT_NOW(a_index_steps, rsp_valid && $past(rsp_valid) && !$past(rsp_last_view),
      rsp_view_index == ($past(rsp_view_index) + IDX_W'(1)))
   `SSVT_ASSERT_NOW(a_x_inside, rsp_valid, x_end <= {1'b0, frame_width_ff})
   `SSVT_ASSERT_NOW(a_y_inside, rsp_valid, y_end <= {1'b0, frame_height_ff})

endmodule
